>>> src/duplicate_check_rank_assign_core_assert.svh
// ----------------------------------------------------------------------------
// duplicate check rank assign core assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_CHECK_RANK_ASSIGN_CORE_ASSERT_SVH
`define DUPLICATE_CHECK_RANK_ASSIGN_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DCRA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define DCRA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DCRA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DCRA_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> src/dcra_pkg.sv
// ----------------------------------------------------------------------------
// dcra_pkg
// shared widths, codes, state and command types of the rank assign core
// ----------------------------------------------------------------------------
package dcra_pkg;

   // sizes
   localparam int MAX_COUNT = 64;
   localparam int VALUE_W   = 32;
   localparam int RANK_W    = 6;
   localparam int STATUS_W  = 2;
   localparam int ADDR_W    = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
   localparam int CNT_W     = $clog2(MAX_COUNT + 1);
   localparam int ENTRY_W   = VALUE_W + RANK_W;

   localparam logic [CNT_W-1:0] MAX_COUNT_C = CNT_W'(MAX_COUNT);

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVF = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STORE,
      ST_REPORT,
      ST_LOAD,
      ST_WAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_en;
      logic set_ovf;
      logic store;
      logic emit_err;
      logic emit_rd;
      logic emit_ld;
      logic clear_run;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic scan_done;
      logic last_item;
      logic err;
      logic rsp_done;
      logic rsp_final;
   } status_type;

endpackage

>>> src/dcra_if.sv
// ----------------------------------------------------------------------------
// dcra channel interfaces
// valid/ready channels for input values and rank results
// ----------------------------------------------------------------------------

// input value channel
interface dcra_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [dcra_pkg::VALUE_W-1:0] value;
   logic                               is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

// rank result channel
interface dcra_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dcra_pkg::RANK_W-1:0]    rank;
   logic [dcra_pkg::STATUS_W-1:0]  status;
   logic                           last_out;

   modport source (output valid, output rank, output status, output last_out, input ready);
   modport sink   (input valid, input rank, input status, input last_out, output ready);
endinterface

>>> src/dcra_ram.sv
// ----------------------------------------------------------------------------
// dcra_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dcra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/dcra_ctrl.sv
// ----------------------------------------------------------------------------
// dcra_ctrl
// sequencer for accept, compare scan, store and result emission
// ----------------------------------------------------------------------------
module dcra_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dcra_pkg::status_type stat,
   output dcra_pkg::cmd_type    cmd
);

   dcra_pkg::state_type state_ff;
   dcra_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         dcra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = dcra_pkg::ST_SCAN;
            end
         end
         dcra_pkg::ST_SCAN: begin
            if (stat.full) begin
               // set is already full, value dropped
               cmd.set_ovf = 1'b1;
               state_in    = stat.last_item ? dcra_pkg::ST_REPORT : dcra_pkg::ST_IDLE;
            end else begin
               cmd.scan_en = 1'b1;
               if (stat.scan_done) begin
                  state_in = dcra_pkg::ST_STORE;
               end
            end
         end
         dcra_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = stat.last_item ? dcra_pkg::ST_REPORT : dcra_pkg::ST_IDLE;
         end
         dcra_pkg::ST_REPORT: begin
            if (stat.err) begin
               cmd.emit_err = 1'b1;
               state_in     = dcra_pkg::ST_WAIT;
            end else begin
               cmd.emit_rd = 1'b1;
               state_in    = dcra_pkg::ST_LOAD;
            end
         end
         dcra_pkg::ST_LOAD: begin
            cmd.emit_ld = 1'b1;
            state_in    = dcra_pkg::ST_WAIT;
         end
         dcra_pkg::ST_WAIT: begin
            if (stat.rsp_done) begin
               if (stat.rsp_final) begin
                  cmd.clear_run = 1'b1;
                  state_in      = dcra_pkg::ST_IDLE;
               end else begin
                  cmd.emit_rd = 1'b1;
                  state_in    = dcra_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = dcra_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/dcra_datapath.sv
// ----------------------------------------------------------------------------
// dcra_datapath
// entry ram, compare stage, run flags, counters and result register
// ----------------------------------------------------------------------------
`include "duplicate_check_rank_assign_core_assert.svh"

module dcra_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dcra_pkg::cmd_type                     cmd,
   output dcra_pkg::status_type                  stat,
   input  logic signed [dcra_pkg::VALUE_W-1:0]   req_value,
   input  logic                                  req_is_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dcra_pkg::RANK_W-1:0]           rsp_rank,
   output logic [dcra_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_last_out
);

   // run state
   logic [dcra_pkg::CNT_W-1:0]          entry_count_ff, entry_count_in;
   logic                                dup_ff, dup_in;
   logic                                ovf_ff, ovf_in;
   logic [dcra_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic                                cmp_valid_ff, cmp_valid_in;
   logic [dcra_pkg::ADDR_W-1:0]         cmp_idx_ff, cmp_idx_in;
   // current item
   logic signed [dcra_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                                last_ff, last_in;
   logic [dcra_pkg::RANK_W-1:0]         own_ff, own_in;
   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [dcra_pkg::RANK_W-1:0]         rsp_rank_ff, rsp_rank_in;
   logic [dcra_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                                rsp_last_ff, rsp_last_in;

   // ram ports
   logic                                ram_wr_en;
   logic [dcra_pkg::ADDR_W-1:0]         ram_wr_addr;
   logic [dcra_pkg::ENTRY_W-1:0]        ram_wr_data;
   logic                                ram_rd_en;
   logic [dcra_pkg::ENTRY_W-1:0]        ram_rd_data;

   logic signed [dcra_pkg::VALUE_W-1:0] stored_value;
   logic [dcra_pkg::RANK_W-1:0]         stored_rank;
   logic                                scan_step;
   logic                                rsp_done;

   // each entry holds value and rank side by side
   dcra_ram #(
      .WIDTH (dcra_pkg::ENTRY_W),
      .DEPTH (dcra_pkg::MAX_COUNT)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[dcra_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign stored_value = ram_rd_data[dcra_pkg::ENTRY_W-1:dcra_pkg::RANK_W];
   assign stored_rank  = ram_rd_data[dcra_pkg::RANK_W-1:0];
   assign scan_step    = cmd.scan_en && (idx_ff != entry_count_ff);
   assign rsp_done     = rsp_valid_ff && rsp_ready;
   assign ram_rd_en    = scan_step || cmd.emit_rd;

   // ram write: rank bump of a larger stored value, or the new entry
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cmp_idx_ff;
      ram_wr_data = {stored_value, stored_rank + dcra_pkg::RANK_W'(1)};
      if (cmd.store) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = entry_count_ff[dcra_pkg::ADDR_W-1:0];
         ram_wr_data = {value_ff, own_ff};
      end else if (cmp_valid_ff && (stored_value > value_ff)) begin
         ram_wr_en = 1'b1;
      end
   end

   // next values
   always_comb begin
      entry_count_in = entry_count_ff;
      dup_in         = dup_ff;
      ovf_in         = ovf_ff;
      idx_in         = idx_ff;
      cmp_valid_in   = scan_step;
      cmp_idx_in     = idx_ff[dcra_pkg::ADDR_W-1:0];
      value_in       = value_ff;
      last_in        = last_ff;
      own_in         = own_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_rank_in    = rsp_rank_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      // latch item and restart the scan
      if (cmd.accept) begin
         value_in = req_value;
         last_in  = req_is_last;
         own_in   = '0;
         idx_in   = '0;
      end

      // issue next read
      if (scan_step) begin
         idx_in = idx_ff + dcra_pkg::CNT_W'(1);
      end

      // compare stage on returned entry
      if (cmp_valid_ff) begin
         if (stored_value == value_ff) begin
            dup_in = 1'b1;
         end else if (stored_value < value_ff) begin
            own_in = own_ff + dcra_pkg::RANK_W'(1);
         end
      end

      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end

      if (cmd.store) begin
         entry_count_in = entry_count_ff + dcra_pkg::CNT_W'(1);
         idx_in         = '0;
      end

      // result beat handed off
      if (rsp_done) begin
         rsp_valid_in = 1'b0;
      end

      // single error beat, overflow wins
      if (cmd.emit_err) begin
         rsp_valid_in  = 1'b1;
         rsp_rank_in   = '0;
         rsp_status_in = ovf_ff ? dcra_pkg::STATUS_OVF : dcra_pkg::STATUS_DUP;
         rsp_last_in   = 1'b1;
      end

      // rank beat from ram read data
      if (cmd.emit_ld) begin
         rsp_valid_in  = 1'b1;
         rsp_rank_in   = stored_rank;
         rsp_status_in = dcra_pkg::STATUS_OK;
         rsp_last_in   = ((idx_ff + dcra_pkg::CNT_W'(1)) == entry_count_ff);
         idx_in        = idx_ff + dcra_pkg::CNT_W'(1);
      end

      if (cmd.clear_run) begin
         entry_count_in = '0;
         dup_in         = 1'b0;
         ovf_in         = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         dup_ff         <= 1'b0;
         ovf_ff         <= 1'b0;
         idx_ff         <= '0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         dup_ff         <= dup_in;
         ovf_ff         <= ovf_in;
         idx_ff         <= idx_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      value_ff      <= value_in;
      last_ff       <= last_in;
      own_ff        <= own_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // status to controller
   always_comb begin
      stat.full      = (entry_count_ff == dcra_pkg::MAX_COUNT_C);
      stat.scan_done = (idx_ff == entry_count_ff) && !cmp_valid_ff;
      stat.last_item = last_ff;
      stat.err       = ovf_ff || dup_ff;
      stat.rsp_done  = rsp_done;
      stat.rsp_final = rsp_last_ff;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rank     = rsp_rank_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last_out = rsp_last_ff;

   // checks
   `DCRA_ASSERT_IMP(a_store_no_cmp_write, clock, reset, cmd.store, !cmp_valid_ff, "store collides with rank update")
   `DCRA_ASSERT_IMP(a_store_not_full, clock, reset, cmd.store, entry_count_ff < dcra_pkg::MAX_COUNT_C, "store into full set")
   `DCRA_ASSERT_IMP(a_load_no_overwrite, clock, reset, cmd.emit_ld || cmd.emit_err, !rsp_valid_ff, "pending result overwritten")
   `DCRA_ASSERT_NXT(a_scan_bound, clock, reset, cmd.scan_en, idx_ff <= entry_count_ff, "scan index past entry count")

endmodule

>>> src/duplicate_check_rank_assign_core.sv
// ----------------------------------------------------------------------------
// duplicate_check_rank_assign_core
// ranks a set of signed values by pairwise compare, flags overflow and duplicates
// ----------------------------------------------------------------------------
//   channel   dir  payload                      transfer
//   req_ch    in   value[31:0], is_last         valid & ready
//   rsp_ch    out  rank[5:0], status[1:0],      valid & ready
//                  last_out
//
// for each value the compare scan reads one stored entry per cycle through
// the single entry ram read port, then drains the compare stage and stores.
// each result beat is a ram read, then a load into the result register; after
// the first, each read is issued with the handoff of the beat before it.
// synchronous reset clears run state only, no ram clearing pass is needed.
// req_ch is ready only between items; rsp_ch stalls hold the result register.
// ----------------------------------------------------------------------------
module duplicate_check_rank_assign_core (
   input  logic          clock,
   input  logic          reset,
   dcra_req_if.sink      req_ch,
   dcra_rsp_if.source    rsp_ch
);

   dcra_pkg::cmd_type    cmd;
   dcra_pkg::status_type stat;

   // sequencer
   dcra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // entry store, compare and result path
   dcra_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_value    (req_ch.value),
      .req_is_last  (req_ch.is_last),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_rank     (rsp_ch.rank),
      .rsp_status   (rsp_ch.status),
      .rsp_last_out (rsp_ch.last_out)
   );

endmodule

>>> tb/tb_duplicate_check_rank_assign_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_duplicate_check_rank_assign_core
// drives sets of signed values into the rank core and checks every rank beat
// against an in-bench rank and duplicate predictor or a typed-in result, under
// varying idle and stall patterns on both channels
// ----------------------------------------------------------------------------
module tb_duplicate_check_rank_assign_core;

   localparam logic signed [dcra_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [dcra_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam int SMALL_ITEMS = 22;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [dcra_pkg::RANK_W-1:0]   rank;
      logic [dcra_pkg::STATUS_W-1:0] status;
      logic                          last_out;
   } rank_result_type;

   // directed row: fixed_exp marks a row whose single result is typed in
   typedef struct packed {
      logic signed [dcra_pkg::VALUE_W-1:0] value;
      logic                                is_last;
      logic                                fixed_exp;
      logic [dcra_pkg::RANK_W-1:0]         rank;
      logic [dcra_pkg::STATUS_W-1:0]       status;
   } dir_row_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   req_idle_pct;
   int   rsp_stall_pct;

   dcra_req_if req_ch ();
   dcra_rsp_if rsp_ch ();

   duplicate_check_rank_assign_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // predictor state: stored set, running ranks, run flags
   logic signed [dcra_pkg::VALUE_W-1:0] set_store [dcra_pkg::MAX_COUNT];
   logic [dcra_pkg::RANK_W-1:0]         set_rank  [dcra_pkg::MAX_COUNT];
   int                                  set_count;
   bit                                  set_dup;
   bit                                  set_ovf;
   rank_result_type                     rank_expect_q [$];
   logic signed [dcra_pkg::VALUE_W-1:0] set_vals [$];

   dir_row_type directed_rows [23] = '{
      // single-value sets at the extremes
      '{VAL_MIN,        1'b1, 1'b1, 6'd0, dcra_pkg::STATUS_OK},
      '{VAL_MAX,        1'b1, 1'b1, 6'd0, dcra_pkg::STATUS_OK},
      '{32'sh0,         1'b1, 1'b1, 6'd0, dcra_pkg::STATUS_OK},
      // mixed extremes
      '{VAL_MAX,        1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{VAL_MIN,        1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'sh0,         1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'shFFFF_FFFF, 1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'sh1,         1'b1, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      // duplicate pair
      '{32'sh5,         1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'shFFFF_FFFB, 1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'sh5,         1'b1, 1'b1, 6'd0, dcra_pkg::STATUS_DUP},
      // duplicated extremes
      '{VAL_MIN,        1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{VAL_MAX,        1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{VAL_MIN,        1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{VAL_MAX,        1'b1, 1'b1, 6'd0, dcra_pkg::STATUS_DUP},
      // ascending
      '{32'sh1,         1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'sh2,         1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'sh3,         1'b1, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      // descending
      '{32'sh3,         1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'sh2,         1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'sh1,         1'b1, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      // adjacent negatives
      '{32'shFFFF_FFFE, 1'b0, 1'b0, 6'd0, dcra_pkg::STATUS_OK},
      '{32'shFFFF_FFFF, 1'b1, 1'b0, 6'd0, dcra_pkg::STATUS_OK}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // overall time limit
   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_fail(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   // rank update for one accepted value; queues the results of a final value
   task automatic rank_predict(input logic signed [dcra_pkg::VALUE_W-1:0] v,
                               input logic last, input bit keep);
      logic [dcra_pkg::RANK_W-1:0] own;
      rank_result_type             res;
      if (set_count >= dcra_pkg::MAX_COUNT) begin
         set_ovf = 1'b1;
      end else begin
         own = '0;
         for (int i = 0; i < set_count; i++) begin
            if (set_store[i] == v) set_dup = 1'b1;
            else if (set_store[i] > v) set_rank[i] = set_rank[i] + 1'b1;
            else own = own + 1'b1;
         end
         set_store[set_count] = v;
         set_rank[set_count]  = own;
         set_count++;
      end
      if (!last) return;
      // overflow wins over duplicate
      if (set_ovf || set_dup) begin
         res.rank     = '0;
         res.status   = set_ovf ? dcra_pkg::STATUS_OVF : dcra_pkg::STATUS_DUP;
         res.last_out = 1'b1;
         if (keep) rank_expect_q.push_back(res);
      end else begin
         for (int i = 0; i < set_count; i++) begin
            res.rank     = set_rank[i];
            res.status   = dcra_pkg::STATUS_OK;
            res.last_out = (i == set_count - 1);
            if (keep) rank_expect_q.push_back(res);
         end
      end
      set_count = 0;
      set_dup   = 1'b0;
      set_ovf   = 1'b0;
   endtask

   // one input beat, with random idle cycles ahead of it
   task automatic send_value(input logic signed [dcra_pkg::VALUE_W-1:0] v,
                             input logic last, input bit keep);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.value   <= v;
      req_ch.is_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      rank_predict(v, last, keep);
   endtask

   function automatic logic signed [dcra_pkg::VALUE_W-1:0] pick_value();
      logic signed [dcra_pkg::VALUE_W-1:0] v;
      case ($urandom_range(3))
         0: v = $urandom_range(16) - 8;
         1: begin
            case ($urandom_range(5))
               0: v = VAL_MIN;
               1: v = VAL_MIN + 1;
               2: v = VAL_MAX;
               3: v = VAL_MAX - 1;
               4: v = 32'sh0;
               default: v = 32'shFFFF_FFFF;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // distinct values, optionally with one copy of an earlier stored value
   task automatic make_set(input int size, input bit with_dup);
      logic signed [dcra_pkg::VALUE_W-1:0] v;
      bit hit;
      int dst;
      int src;
      set_vals.delete();
      for (int k = 0; k < size; k++) begin
         do begin
            v = pick_value();
            hit = 1'b0;
            foreach (set_vals[j]) if (set_vals[j] == v) hit = 1'b1;
         end while (hit);
         set_vals.push_back(v);
      end
      if (with_dup && size > 1) begin
         dst = $urandom_range((size - 1 < dcra_pkg::MAX_COUNT - 1) ?
                              size - 1 : dcra_pkg::MAX_COUNT - 1, 1);
         src = $urandom_range(dst - 1, 0);
         set_vals[dst] = set_vals[src];
      end
   endtask

   // result side: random stall and in-order check of every beat
   initial begin
      rank_result_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (rank_expect_q.size() == 0) begin
               report_fail($sformatf("unexpected beat: rank %0d status %0d last %0d",
                                     rsp_ch.rank, rsp_ch.status, rsp_ch.last_out));
            end else begin
               want = rank_expect_q.pop_front();
               if (rsp_ch.rank !== want.rank)
                  report_fail($sformatf("rank: got %0d expected %0d",
                                        rsp_ch.rank, want.rank));
               if (rsp_ch.status !== want.status)
                  report_fail($sformatf("status: got %0d expected %0d",
                                        rsp_ch.status, want.status));
               if (rsp_ch.last_out !== want.last_out)
                  report_fail($sformatf("last_out: got %0d expected %0d",
                                        rsp_ch.last_out, want.last_out));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // stimulus
   initial begin
      int              set_no;
      int              small_items;
      int              size;
      bit              with_dup;
      rank_result_type fixed_res;
      fail_count     = 0;
      req_idle_pct   = 0;
      rsp_stall_pct  = 0;
      set_count      = 0;
      set_dup        = 1'b0;
      set_ovf        = 1'b0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.value   <= '0;
      req_ch.is_last <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, no idling
      foreach (directed_rows[r]) begin
         send_value(directed_rows[r].value, directed_rows[r].is_last,
                    !directed_rows[r].fixed_exp);
         if (directed_rows[r].fixed_exp) begin
            fixed_res.rank     = directed_rows[r].rank;
            fixed_res.status   = directed_rows[r].status;
            fixed_res.last_out = 1'b1;
            rank_expect_q.push_back(fixed_res);
         end
      end

      // random sets; one overflow run that also holds a duplicate is mixed in
      set_no      = 0;
      small_items = 0;
      while (small_items < SMALL_ITEMS || set_no < 5) begin
         case (set_no % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 64; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin req_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         case (set_no)
            2: begin size = dcra_pkg::MAX_COUNT + 1; with_dup = 1'b1; end
            default: begin
               size     = $urandom_range(10, 1);
               with_dup = ($urandom_range(4) == 0);
               small_items += size;
            end
         endcase
         make_set(size, with_dup);
         foreach (set_vals[k]) send_value(set_vals[k], k == size - 1, 1'b1);
         set_no++;
      end
      req_ch.valid <= 1'b0;

      // drain
      while (rank_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
